### rtl/teabd_pkg.sv
// Shared types, constants and helpers for the TEA block decryption pipeline.
package teabd_pkg;

    localparam int unsigned ROUNDS     = 32;
    localparam int unsigned STAGES     = 2 * ROUNDS;
    localparam logic [31:0] DELTA      = 32'h9E37_79B9;
    localparam int unsigned CFG_IDX_W  = 8;

    // Key register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] KEY_WORD_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] KEY_WORD_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] KEY_WORD_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] KEY_WORD_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [31:0] cipher_high;
        logic [31:0] cipher_low;
        logic        last_block;
    } cipher_t;

    typedef struct packed {
        logic [31:0] plain_high;
        logic [31:0] plain_low;
        logic        last_out;
    } plain_t;

    // Working block as it travels down the pipeline
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        last;
    } blk_t;

    // Per-stage control and round constants
    typedef struct packed {
        logic        advance;
        logic        upd_right;
        logic [31:0] sum;
        logic [31:0] key_a;
        logic [31:0] key_b;
    } stage_ctrl_t;

    // Running sum seen by round r: DELTA * (ROUNDS - r) modulo 2^32
    function automatic logic [31:0] round_sum(int unsigned r);
        logic [63:0] prod;
        prod = 64'(ROUNDS - r) * 64'(DELTA);
        return prod[31:0];
    endfunction

    // TEA mixing function
    function automatic logic [31:0] tea_mix(logic [31:0] v, logic [31:0] sum,
                                            logic [31:0] ka, logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

### rtl/teabd_stage.sv
// One registered half-round of TEA decryption.
module teabd_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  teabd_pkg::stage_ctrl_t ctrl,
    input  logic                 valid_in,
    input  teabd_pkg::blk_t      data_in,
    output logic                 valid_out,
    output teabd_pkg::blk_t      data_out
);
    import teabd_pkg::*;

    logic        valid_reg;
    blk_t        data_reg;
    blk_t        data_next;
    logic [31:0] mix_src;
    logic [31:0] mix_val;

    // Mix the half not being updated, subtract from the other
    always_comb
    begin
        data_next = data_in;
        mix_src   = ctrl.upd_right ? data_in.left : data_in.right;
        mix_val   = tea_mix(mix_src, ctrl.sum, ctrl.key_a, ctrl.key_b);
        if (ctrl.upd_right)
        begin
            data_next.right = data_in.right - mix_val;
        end
        else
        begin
            data_next.left = data_in.left - mix_val;
        end
    end

    // Advance valid with the data; hold both on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### rtl/tea_block_decrypt.sv
// Top level of the pipelined TEA block decryption engine.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one 64-bit ciphertext
//   block per transfer, as two big-endian words plus a last-block flag.
//   Output channel (out_valid/out_ready/out_data) returns the plaintext
//   block and the flag, one result per input block, in order.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   the four 32-bit key words at indexes 0 to 3; other indexes are dropped.
//   The user must change keys only while no block is in flight; the block itself does not enforce this.
// Timing:
//   Each round is split into two half-round stages, 64 register stages in
//   all between the input transfer and out_valid. Throughput is one block
//   per cycle when the receiver does not stall.
// Reset:
//   rst_n clears all stage valid bits and the key words (all-zero key).
// Stall:
//   While a result waits with out_ready low the whole pipeline freezes and
//   in_ready drops; nothing is lost or repeated. Empty slots keep moving
//   only when the output register is free or being taken.
module tea_block_decrypt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  teabd_pkg::cipher_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output teabd_pkg::plain_t              out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [teabd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import teabd_pkg::*;

    logic [31:0]      key_reg [4];
    logic             advance;
    logic [STAGES:0]  stage_valid;
    blk_t             stage_data [STAGES+1];

    // Key register file; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                KEY_WORD_0: key_reg[0] <= cfg_data;
                KEY_WORD_1: key_reg[1] <= cfg_data;
                KEY_WORD_2: key_reg[2] <= cfg_data;
                KEY_WORD_3: key_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Freeze the pipeline while the output register holds an untaken result
    assign advance  = !stage_valid[STAGES] || out_ready;
    assign in_ready = advance;

    // Feed stage zero from the input channel
    assign stage_valid[0]     = in_valid;
    assign stage_data[0].left  = in_data.cipher_high;
    assign stage_data[0].right = in_data.cipher_low;
    assign stage_data[0].last  = in_data.last_block;

    // Half-round stages: even ones update the right half, odd the left
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        stage_ctrl_t ctrl;

        always_comb
        begin
            ctrl.advance   = advance;
            ctrl.upd_right = ((k % 2) == 0);
            ctrl.sum       = round_sum(k / 2);
            ctrl.key_a     = ((k % 2) == 0) ? key_reg[2] : key_reg[0];
            ctrl.key_b     = ((k % 2) == 0) ? key_reg[3] : key_reg[1];
        end

        teabd_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .valid_in  (stage_valid[k]),
            .data_in   (stage_data[k]),
            .valid_out (stage_valid[k+1]),
            .data_out  (stage_data[k+1])
        );
    end

    // Last stage is the output register
    assign out_valid           = stage_valid[STAGES];
    assign out_data.plain_high = stage_data[STAGES].left;
    assign out_data.plain_low  = stage_data[STAGES].right;
    assign out_data.last_out   = stage_data[STAGES].last;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> stage_valid[1])
        else $error("accepted block did not enter the first stage");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stage_valid[STAGES:1]))
        else $error("pipeline valid bits moved during a stall");

    a_out_rise_advanced: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance))
        else $error("result appeared without the pipeline advancing");

    a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input transfer taken while the output is stalled");
`endif

endmodule

### sim/tea_block_decrypt_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TEA block decryption engine with random flow control.
module tea_block_decrypt_tb;
    import teabd_pkg::*;

    localparam int unsigned RAND_PHASES      = 13;
    localparam int unsigned BLOCKS_PER_PHASE = 100;
    localparam int unsigned MAX_GAP          = 7;
    localparam int unsigned IDLE_CYCLES      = 4;
    localparam int unsigned SETTLE_CYCLES    = STAGES + 16;
    localparam int unsigned DIR_ROWS         = 8;
    localparam int unsigned JUNK_IDX_MIN     = int'(KEY_WORD_3) + 1;
    localparam int unsigned JUNK_IDX_MAX     = 2 ** CFG_IDX_W - 1;
    localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;
    localparam time         RUN_LIMIT        = 3_000_000;

    // One directed block, with the plaintext typed in where it is a known answer
    typedef struct packed {
        cipher_t blk;
        logic    known;
        plain_t  want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    cipher_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    plain_t               out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Predictor copy of the key and the plaintexts still owed by the engine
    logic [31:0] key_word [0:3];
    plain_t      plain_q [$];
    plain_t      oldest_plain;

    bit          no_idle;
    int unsigned fail_count;
    int unsigned blocks_sent;
    int unsigned results_checked;
    int unsigned cfg_writes;
    int unsigned key_loads;

    // Zero-key known answer first, then field extremes and both flag values
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{'{32'h41EA_3A0A, 32'h94BA_A940, 1'b0}, 1'b1, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h41EA_3A0A, 32'h94BA_A940, 1'b1}, 1'b1, '{32'h0, 32'h0, 1'b1}},
        '{'{32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h8000_0000, 32'h0000_0001, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h0000_0001, 32'h8000_0000, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}}
    };

    tea_block_decrypt i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Generate 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Round function of one half-round
    function automatic logic [31:0] feistel_mix(logic [31:0] v, logic [31:0] sum,
                                                logic [31:0] ka, logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    // Decrypt one block under the current key
    function automatic plain_t tea_decipher(cipher_t c);
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] sum;
        plain_t      p;
        left  = c.cipher_high;
        right = c.cipher_low;
        sum   = DELTA * ROUNDS;
        for (int r = 0; r < ROUNDS; r++)
        begin
            right = right - feistel_mix(left, sum, key_word[2], key_word[3]);
            left  = left - feistel_mix(right, sum, key_word[0], key_word[1]);
            sum   = sum - DELTA;
        end
        p.plain_high = left;
        p.plain_low  = right;
        p.last_out   = c.last_block;
        return p;
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Mostly random words, with the extremes mixed in
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return ALL_ONES;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Offer one block from a falling edge; return at the falling edge after its transfer
    task automatic send_block(input cipher_t blk, input logic known, input plain_t want);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        plain_q.push_back(known ? want : tea_decipher(blk));
        blocks_sent++;
        @(negedge clk);
    endtask

    // Write one register; the caller drops cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            KEY_WORD_0: key_word[0] = data;
            KEY_WORD_1: key_word[1] = data;
            KEY_WORD_2: key_word[2] = data;
            KEY_WORD_3: key_word[3] = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    // Load a 128-bit key, sometimes with a write to an unused index around it
    task automatic set_key(input logic [127:0] key);
        bit junk_first;
        junk_first = 1'($urandom_range(0, 1));
        if (junk_first)
            write_reg(CFG_IDX_W'($urandom_range(JUNK_IDX_MIN, JUNK_IDX_MAX)), $urandom());
        write_reg(KEY_WORD_0, key[127:96]);
        write_reg(KEY_WORD_1, key[95:64]);
        write_reg(KEY_WORD_2, key[63:32]);
        write_reg(KEY_WORD_3, key[31:0]);
        if (!junk_first && $urandom_range(0, 1))
            write_reg(CFG_IDX_W'($urandom_range(JUNK_IDX_MIN, JUNK_IDX_MAX)), $urandom());
        cfg_valid <= 1'b0;
        key_loads++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed plaintext has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (plain_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    // Stimulus and end of run
    initial
    begin
        cipher_t     blk;
        logic [127:0] key;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        no_idle     = 1'b0;
        key_word[0] = '0;
        key_word[1] = '0;
        key_word[2] = '0;
        key_word[3] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: once under the reset key, once under the all-ones key
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                wait_idle();
                set_key({4{ALL_ONES}});
            end
            for (int row = 0; row < DIR_ROWS; row++)
                send_block(dir_tab[row].blk, dir_tab[row].known && pass == 0,
                           dir_tab[row].want);
        end

        // Random phases, each under a fresh key and flow-control mode
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            for (int w = 0; w < 4; w++)
            begin
                case ($urandom_range(0, 3))
                    0: key[127 - 32 * w -: 32] = 32'h0000_0000;
                    1: key[127 - 32 * w -: 32] = ALL_ONES;
                    default: key[127 - 32 * w -: 32] = $urandom();
                endcase
            end
            no_idle = ($urandom_range(0, 3) == 0);
            set_key(key);
            for (int n = 0; n < BLOCKS_PER_PHASE; n++)
            begin
                blk.cipher_high = rand_word();
                blk.cipher_low  = rand_word();
                blk.last_block  = 1'($urandom_range(0, 1));
                send_block(blk, 1'b0, '0);
            end
        end

        // Drain and let any stray result show up
        in_valid <= 1'b0;
        while (plain_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Decrypted %0d blocks under %0d key loads (%0d register writes).",
                 blocks_sent, key_loads, cfg_writes);
        $display("Compared %0d plaintext results, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random hold-off before each result, then take it
    initial
    begin
        int unsigned gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Check each output transfer against the oldest owed plaintext
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (plain_q.size() == 0)
            begin
                $display("%0t: unexpected result %08h %08h last=%0b", $time,
                         out_data.plain_high, out_data.plain_low, out_data.last_out);
                fail_count++;
            end
            else
            begin
                oldest_plain = plain_q.pop_front();
                results_checked++;
                if (out_data.plain_high !== oldest_plain.plain_high)
                begin
                    $display("%0t: plain_high expected %08h, got %08h", $time,
                             oldest_plain.plain_high, out_data.plain_high);
                    fail_count++;
                end
                if (out_data.plain_low !== oldest_plain.plain_low)
                begin
                    $display("%0t: plain_low expected %08h, got %08h", $time,
                             oldest_plain.plain_low, out_data.plain_low);
                    fail_count++;
                end
                if (out_data.last_out !== oldest_plain.last_out)
                begin
                    $display("%0t: last_out expected %0b, got %0b", $time,
                             oldest_plain.last_out, out_data.last_out);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("Run did not finish in time.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### tea_block_decrypt.f
rtl/teabd_pkg.sv
rtl/teabd_stage.sv
rtl/tea_block_decrypt.sv
sim/tea_block_decrypt_tb.sv
